// File: design/pfcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfcb_pkg
// Shared types and constants for the blit pixel format converter: register
// map, reset values, palette size and the default row-width limit.
// ----------------------------------------------------------------------------
package pfcb_pkg;

  // Row width limit and palette size
  localparam int unsigned MAX_ROW_WIDTH_DEF = 4096;
  localparam int unsigned PAL_ENTRIES       = 256;
  localparam int unsigned PAL_IDX_W         = $clog2(PAL_ENTRIES);

  // Field widths
  localparam int unsigned PIX_W    = 32;
  localparam int unsigned COL_W    = 12;
  localparam int unsigned BYTES_W  = 3;
  localparam int unsigned RW_W     = 13;
  localparam int unsigned APB_W    = 32;
  localparam int unsigned PADDR_W  = 5;
  localparam int unsigned REG_IDX_W = 3;

  // Reset values
  localparam logic [BYTES_W-1:0] BYTES_RST = BYTES_W'(4);
  localparam logic [RW_W-1:0]    RW_RST    = RW_W'(4096);

  // Fixed byte values
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  // Request kinds
  localparam logic ACT_PIXEL   = 1'b0;
  localparam logic ACT_PAL_WR  = 1'b1;

  // Register map, word index = paddr[4:2]
  typedef enum logic [REG_IDX_W-1:0] {
    REG_SRC_BYTES   = 3'd0,
    REG_TGT_BYTES   = 3'd1,
    REG_ROW_WIDTH   = 3'd2,
    REG_FLIP_EN     = 3'd3,
    REG_TRANSP_EN   = 3'd4,
    REG_GRAY_EN     = 3'd5,
    REG_PAL_EN      = 3'd6
  } cfg_reg_t;

  // Mask of the low nbytes bytes of a pixel
  function automatic logic [PIX_W-1:0] byte_mask(input logic [BYTES_W-1:0] nbytes);
    logic [PIX_W-1:0] m;
    case (nbytes)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// File: design/pixel_format_convert_blit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_format_convert_blit
// Converts source pixels into target pixel writes for a blit: copy, mirror,
// transparent skip, grayscale expand, palette lookup or alpha expand, with a
// column counter that wraps at the row width.
//
//   channel  dir  handshake            payload
//   in_      in   in_valid / in_stall   action, pixel_in, palette_index,
//                                       palette_color
//   out_     out  out_valid / out_stall column, pixel_out, write_enable,
//                                       row_end, bad_format
//   apb      in   psel/penable/pready   paddr, pwdata, prdata
//
// One request per cycle sustained while out_stall is low; a pixel passes
// through the input stage (with the palette read), then the result register,
// before it is presented on the output, and out_stall can hold it in either.
// A palette write is done at acceptance and produces no result.
// Reset clears control state and configuration; the palette is not cleared.
// The user must write an entry before it is read; the block does not check.
// out_stall holds a valid result register and, when the input stage is also
// full, raises in_stall in the same cycle.
// ----------------------------------------------------------------------------
module pixel_format_convert_blit #(
  parameter int unsigned MAX_ROW_WIDTH = pfcb_pkg::MAX_ROW_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input requests
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_action,
  input  logic [pfcb_pkg::PIX_W-1:0]      in_pixel_in,
  input  logic [pfcb_pkg::PAL_IDX_W-1:0]  in_palette_index,
  input  logic [pfcb_pkg::PIX_W-1:0]      in_palette_color,
  // results
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pfcb_pkg::COL_W-1:0]      out_column,
  output logic [pfcb_pkg::PIX_W-1:0]      out_pixel_out,
  output logic                            out_write_enable,
  output logic                            out_row_end,
  output logic                            out_bad_format,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pfcb_pkg::PADDR_W-1:0]    paddr,
  input  logic [pfcb_pkg::APB_W-1:0]      pwdata,
  output logic [pfcb_pkg::APB_W-1:0]      prdata,
  output logic                            pready
);
  import pfcb_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ROW_WIDTH);
  localparam int unsigned WW    = (CNT_W + 1 > RW_W) ? CNT_W + 1 : RW_W;
  localparam logic [WW-1:0] MAX_W = WW'(MAX_ROW_WIDTH);

  // Configuration registers
  logic [BYTES_W-1:0] src_bytes_r;
  logic [BYTES_W-1:0] tgt_bytes_r;
  logic [RW_W-1:0]    row_width_r;
  logic               flip_en_r;
  logic               transp_en_r;
  logic               gray_en_r;
  logic               pal_en_r;

  logic     cfg_wr;
  cfg_reg_t cfg_idx;

  // Pipeline control
  logic in_accept;
  logic out_load;
  logic s1_adv;
  logic s1_valid_r, s1_valid_nxt;
  logic [PIX_W-1:0] s1_pix_r;
  logic [PIX_W-1:0] pal_rd_r;

  logic [PIX_W-1:0] pal_mem [PAL_ENTRIES];

  // Column counter
  logic [CNT_W-1:0] col_cnt_r, col_cnt_nxt;

  // Datapath
  logic             fmt_same, fmt_expand, fmt_bad;
  logic [WW-1:0]    w_eff;
  logic [WW-1:0]    cnt_ext;
  logic [WW-1:0]    cnt_cur;
  logic [WW-1:0]    col_res;
  logic             rend;
  logic [PIX_W-1:0] pix_res;
  logic             we_res;
  logic [7:0]       f;

  logic               out_valid_r, out_valid_nxt;
  logic [COL_W-1:0]   out_column_r;
  logic [PIX_W-1:0]   out_pixel_r;
  logic               out_we_r;
  logic               out_rend_r;
  logic               out_bad_r;

  // APB decode
  assign pready  = 1'b1;
  assign cfg_idx = cfg_reg_t'(paddr[REG_IDX_W+1:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_bytes_r <= BYTES_RST;
      tgt_bytes_r <= BYTES_RST;
      row_width_r <= RW_RST;
      flip_en_r   <= 1'b0;
      transp_en_r <= 1'b0;
      gray_en_r   <= 1'b0;
      pal_en_r    <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SRC_BYTES: src_bytes_r <= pwdata[BYTES_W-1:0];
        REG_TGT_BYTES: tgt_bytes_r <= pwdata[BYTES_W-1:0];
        REG_ROW_WIDTH: row_width_r <= pwdata[RW_W-1:0];
        REG_FLIP_EN:   flip_en_r   <= pwdata[0];
        REG_TRANSP_EN: transp_en_r <= pwdata[0];
        REG_GRAY_EN:   gray_en_r   <= pwdata[0];
        REG_PAL_EN:    pal_en_r    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_SRC_BYTES: prdata = APB_W'(src_bytes_r);
      REG_TGT_BYTES: prdata = APB_W'(tgt_bytes_r);
      REG_ROW_WIDTH: prdata = APB_W'(row_width_r);
      REG_FLIP_EN:   prdata = APB_W'(flip_en_r);
      REG_TRANSP_EN: prdata = APB_W'(transp_en_r);
      REG_GRAY_EN:   prdata = APB_W'(gray_en_r);
      REG_PAL_EN:    prdata = APB_W'(pal_en_r);
      default:       prdata = '0;
    endcase
  end

  // Handshake: advance the input stage whenever the result register frees up
  assign out_load  = ~out_valid_r | ~out_stall;
  assign s1_adv    = s1_valid_r & out_load;
  assign in_stall  = s1_valid_r & ~out_load;
  assign in_accept = in_valid & ~in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept && in_action == ACT_PIXEL) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Palette: write on palette requests, read on pixel requests
  always_ff @(posedge clk) begin
    if (in_accept && in_action == ACT_PAL_WR) begin
      pal_mem[in_palette_index] <= in_palette_color;
    end
    if (in_accept && in_action == ACT_PIXEL) begin
      pal_rd_r <= pal_mem[in_pixel_in[PAL_IDX_W-1:0]];
    end
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_action == ACT_PIXEL) begin
      s1_pix_r <= in_pixel_in;
    end
  end

  // Format decode
  assign fmt_same   = (src_bytes_r >= BYTES_W'(1)) && (src_bytes_r <= BYTES_W'(4)) &&
                      (src_bytes_r == tgt_bytes_r);
  assign fmt_expand = (src_bytes_r == BYTES_W'(1)) && (tgt_bytes_r == BYTES_W'(4));
  assign fmt_bad    = ~fmt_same & ~fmt_expand;

  // Clamp the row width and wrap a stale count
  always_comb begin
    w_eff = WW'(row_width_r);
    if (row_width_r == '0) begin
      w_eff = WW'(1);
    end else if (WW'(row_width_r) > MAX_W) begin
      w_eff = MAX_W;
    end
    cnt_ext = WW'(col_cnt_r);
    cnt_cur = (cnt_ext >= w_eff) ? '0 : cnt_ext;
    rend    = (cnt_cur == w_eff - WW'(1));
  end

  // Pixel conversion
  assign f = s1_pix_r[7:0];

  always_comb begin
    pix_res = '0;
    we_res  = 1'b1;
    col_res = cnt_cur;
    if (fmt_same) begin
      pix_res = s1_pix_r & byte_mask(src_bytes_r);
      if (flip_en_r) begin
        col_res = w_eff - WW'(1) - cnt_cur;
      end else if (transp_en_r && src_bytes_r == BYTES_W'(4)) begin
        we_res = (s1_pix_r[31:24] != 8'd0);
      end
    end else if (gray_en_r) begin
      pix_res = {ALPHA_OPAQUE, f, f, f};
    end else if (pal_en_r) begin
      pix_res = {f, pal_rd_r[23:0]};
    end else begin
      pix_res = {f, 24'hFF_FFFF};
    end
  end

  // Column count: hold on bad format, wrap at row end
  always_comb begin
    col_cnt_nxt = col_cnt_r;
    if (s1_adv && !fmt_bad) begin
      col_cnt_nxt = rend ? '0 : CNT_W'(cnt_cur + WW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      if (fmt_bad) begin
        out_column_r <= COL_W'(cnt_ext);
        out_pixel_r  <= '0;
        out_we_r     <= 1'b0;
        out_rend_r   <= 1'b0;
        out_bad_r    <= 1'b1;
      end else begin
        out_column_r <= col_res[COL_W-1:0];
        out_pixel_r  <= pix_res;
        out_we_r     <= we_res;
        out_rend_r   <= rend;
        out_bad_r    <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_column       = out_column_r;
  assign out_pixel_out    = out_pixel_r;
  assign out_write_enable = out_we_r;
  assign out_row_end      = out_rend_r;
  assign out_bad_format   = out_bad_r;

endmodule
